// File: hdl/virtqueue_slot_relay_macros.svh
// Assertion macros for the virtqueue slot relay; empty when synthesizing.
`ifndef VIRTQUEUE_SLOT_RELAY_MACROS_SVH
`define VIRTQUEUE_SLOT_RELAY_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define VQSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Check that cons holds in the cycle after ante.
`define VQSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define VQSR_ASSERT_NOW(lbl, ante, cons)
`define VQSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/vqsr_pkg.sv
// Shared types, codes and constants of the virtqueue slot relay.
package vqsr_pkg;

    // Sizes and reset values
    localparam int QUEUE_SIZE_DEF     = 256;
    localparam int RST_QUEUE_SIZE     = 256;
    localparam logic [31:0] RST_MAX_SLOT_BYTES = 32'd4096;
    localparam int QS_W               = 9;
    localparam int POS_W              = 10;
    localparam int DESC_IDX_W         = 9;

    // Item functions
    localparam logic [1:0] FN_SUBMIT   = 2'd0;
    localparam logic [1:0] FN_COMPLETE = 2'd1;
    localparam logic [1:0] FN_LOAD     = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_PUBLISHED = 3'd0;
    localparam logic [2:0] ST_NOSLOT    = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_COMPLETED = 3'd3;
    localparam logic [2:0] ST_DROPPED   = 3'd4;
    localparam logic [2:0] ST_LOADED    = 3'd5;

    // Descriptor layouts
    localparam logic [1:0] KIND_OUT   = 2'd0;
    localparam logic [1:0] KIND_IN    = 2'd1;
    localparam logic [1:0] KIND_CHAIN = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PHYS_BASE = 2'd0;
    localparam logic [1:0] CFG_PHYS_SIZE = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;
    localparam logic [1:0] CFG_QSIZE     = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_tag;
        logic [31:0] out_length;
        logic [31:0] in_length;
        logic [31:0] used_id;
        logic [31:0] used_length;
        logic [8:0]  desc_index;
        logic [63:0] desc_address;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [8:0]  head_desc;
        logic [1:0]  chain_kind;
        logic [8:0]  avail_position;
        logic [15:0] avail_counter_out;
        logic [15:0] tag;
        logic [63:0] buffer_address;
        logic [31:0] done_length;
    } t_result;

    typedef struct packed {
        logic init;
        logic pop;
        logic push;
    } t_stk_ctl;

    typedef struct packed {
        logic clear;
        logic set;
        logic clr;
        logic rd;
    } t_meta_ctl;

endpackage

// File: hdl/vqsr_free_stack.sv
// LIFO free-slot stack in a synchronous memory, with a low-water mark for init.
module vqsr_free_stack #(
    parameter int QUEUE_SIZE = vqsr_pkg::QUEUE_SIZE_DEF,
    localparam int SLOT_W = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1,
    localparam int CNT_W = $clog2(QUEUE_SIZE + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vqsr_pkg::t_stk_ctl i_ctl,
    input  logic [CNT_W-1:0]   i_qs,
    input  logic [SLOT_W-1:0]  i_push_slot,
    output logic [CNT_W-1:0]   o_free_count,
    output logic [SLOT_W-1:0]  o_slot
);
    import vqsr_pkg::*;

    localparam int QS_RESET = (QUEUE_SIZE < RST_QUEUE_SIZE) ? QUEUE_SIZE : RST_QUEUE_SIZE;

    logic [SLOT_W-1:0] r_mem [QUEUE_SIZE];
    logic [CNT_W-1:0]  r_fc, n_fc;
    logic [CNT_W-1:0]  r_lw, n_lw;
    logic              r_from_init;
    logic [SLOT_W-1:0] r_init_val;
    logic [SLOT_W-1:0] r_rd_data;
    logic [CNT_W-1:0]  pop_pos;
    logic              pop_fresh;
    logic              push_ok;

    // Entries below the low-water mark still hold their init value
    assign pop_pos   = r_fc - CNT_W'(1);
    assign pop_fresh = pop_pos < r_lw;
    assign push_ok   = r_fc < CNT_W'(QUEUE_SIZE);

    // Next fill count and low-water mark
    always_comb begin
        n_fc = r_fc;
        n_lw = r_lw;
        if (i_ctl.init) begin
            n_fc = i_qs;
            n_lw = i_qs;
        end else if (i_ctl.pop) begin
            n_fc = pop_pos;
            if (pop_fresh) begin
                n_lw = pop_pos;
            end
        end else if (i_ctl.push && push_ok) begin
            n_fc = r_fc + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= CNT_W'(QS_RESET);
            r_lw        <= CNT_W'(QS_RESET);
            r_from_init <= 1'b0;
        end else begin
            r_fc <= n_fc;
            r_lw <= n_lw;
            if (i_ctl.pop) begin
                r_from_init <= pop_fresh;
            end
        end
    end

    // Read the popped entry and its init value
    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_rd_data  <= r_mem[pop_pos[SLOT_W-1:0]];
            r_init_val <= SLOT_W'(i_qs - CNT_W'(1) - pop_pos);
        end
    end

    // Push a freed slot on top
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && push_ok && !i_ctl.init) begin
            r_mem[r_fc[SLOT_W-1:0]] <= i_push_slot;
        end
    end

    assign o_free_count = r_fc;
    assign o_slot       = r_from_init ? r_init_val : r_rd_data;

endmodule

// File: hdl/vqsr_desc_store.sv
// Descriptor buffer addresses, split into an out bank and an in bank.
module vqsr_desc_store #(
    parameter int QUEUE_SIZE = vqsr_pkg::QUEUE_SIZE_DEF,
    localparam int SLOT_W = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [vqsr_pkg::DESC_IDX_W-1:0] i_load_idx,
    input  logic [63:0]                     i_load_addr,
    input  logic                            i_rd_en,
    input  logic [SLOT_W-1:0]               i_rd_slot,
    output logic [63:0]                     o_out_addr,
    output logic [63:0]                     o_in_addr
);
    import vqsr_pkg::*;

    localparam int DESC_CNT = 2 * QUEUE_SIZE;

    logic [63:0]       r_even [QUEUE_SIZE];
    logic [63:0]       r_odd  [QUEUE_SIZE];
    logic [63:0]       r_out_addr;
    logic [63:0]       r_in_addr;
    logic              load_ok;
    logic [SLOT_W-1:0] load_row;

    // Drop loads past the descriptor table
    assign load_ok  = i_load && (32'(i_load_idx) < 32'(DESC_CNT));
    assign load_row = SLOT_W'(i_load_idx[DESC_IDX_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (load_ok && !i_load_idx[0]) begin
            r_even[load_row] <= i_load_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_load_idx[0]) begin
            r_odd[load_row] <= i_load_addr;
        end
    end

    // Read both descriptors of one slot
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_out_addr <= r_even[i_rd_slot];
            r_in_addr  <= r_odd[i_rd_slot];
        end
    end

    assign o_out_addr = r_out_addr;
    assign o_in_addr  = r_in_addr;

endmodule

// File: hdl/vqsr_slot_meta.sv
// Per-slot in-flight flags plus a memory of request tag and in-part flag.
module vqsr_slot_meta #(
    parameter int QUEUE_SIZE = vqsr_pkg::QUEUE_SIZE_DEF,
    localparam int SLOT_W = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vqsr_pkg::t_meta_ctl i_ctl,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [15:0]         i_tag,
    input  logic                i_has_in,
    output logic                o_inflight,
    output logic [15:0]         o_tag,
    output logic                o_has_in
);
    import vqsr_pkg::*;

    logic [QUEUE_SIZE-1:0] r_inflight;
    logic [16:0]           r_mem [QUEUE_SIZE];
    logic [16:0]           r_rd_data;

    // Track which slots are in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_inflight <= '0;
        end else if (i_ctl.set) begin
            r_inflight[i_slot] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_inflight[i_slot] <= 1'b0;
        end
    end

    // Record tag and in-part flag on publish
    always_ff @(posedge i_clk) begin
        if (i_ctl.set) begin
            r_mem[i_slot] <= {i_has_in, i_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_slot];
        end
    end

    assign o_inflight = r_inflight[i_slot];
    assign o_tag      = r_rd_data[15:0];
    assign o_has_in   = r_rd_data[16];

endmodule

// File: hdl/vqsr_window_chk.sv
// Two-stage check that a buffer lies inside the shared memory window.
module vqsr_window_chk (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [63:0] i_addr,
    input  logic [31:0] i_len,
    input  logic [63:0] i_base,
    input  logic [63:0] i_size,
    output logic        o_ok
);
    logic [64:0] r_diff;
    logic [31:0] r_len;
    logic [64:0] reach;

    // Stage one: offset from the window base, borrow in the top bit
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_diff <= {1'b0, i_addr} - {1'b0, i_base};
            r_len  <= i_len;
        end
    end

    // Stage two: buffer end must not pass the window size
    assign reach = {1'b0, r_diff[63:0]} + 65'(r_len);
    assign o_ok  = !r_diff[64] && (reach <= {1'b0, i_size});

endmodule

// File: hdl/virtqueue_slot_relay.sv
// Split virtqueue driver side: slot allocation, publish, completion, address load.
// Load, no-slot and dropped completion set o_done the cycle after accept; a completion
// passes S_RD and S_CMP, a submit S_POP, S_RD and S_CMP, with busy high until o_done.
// Submit pace is set by the free-stack read, the descriptor memory read and the
// two-stage window check; a load takes one item per cycle while busy is low.
// Synchronous active-low reset; writing the slot count rebuilds the free stack (busy
// high) with no clearing pass. Results cannot be stalled.
`include "virtqueue_slot_relay_macros.svh"

module virtqueue_slot_relay #(
    parameter int QUEUE_SIZE = vqsr_pkg::QUEUE_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  vqsr_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_done,
    output vqsr_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_wdata
);
    import vqsr_pkg::*;

    localparam int SLOT_W = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
    localparam int CNT_W  = $clog2(QUEUE_SIZE + 1);
    localparam int QS_CAP = (QUEUE_SIZE > 511) ? 511 : QUEUE_SIZE;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_RD   = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_item             r_item;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [63:0]       r_base, r_size;
    logic [31:0]       r_max;
    logic [QS_W-1:0]   r_qsz;
    logic              r_init_pend;
    logic [15:0]       r_avail;
    logic [POS_W-1:0]  r_pos;
    logic              r_done, n_done;
    t_result           r_res, n_res;

    logic              accept;
    logic [QS_W-1:0]   qs;
    logic [POS_W-1:0]  w_twice_qs;
    logic [POS_W-1:0]  pos_next;
    logic [CNT_W-1:0]  fc;
    logic [SLOT_W-1:0] stk_slot;
    logic              can_pop;
    logic [30:0]       cpl_slot_full;
    logic [SLOT_W-1:0] cpl_idx;
    logic              cpl_live;
    logic              meta_inflight;
    logic [15:0]       meta_tag;
    logic              meta_has_in;
    logic [SLOT_W-1:0] meta_slot;
    logic [63:0]       out_addr, in_addr;
    logic              win_out_ok, win_in_ok;
    logic [31:0]       win_in_len;
    logic              publish;
    logic              desc_rd_en;
    logic [SLOT_W-1:0] desc_rd_slot;
    logic [SLOT_W-1:0] push_slot;
    t_stk_ctl          stk_ctl;
    t_meta_ctl         meta_ctl;

    // Effective queue size: zero acts as one, clamp to the built depth
    always_comb begin
        if (r_qsz == '0) begin
            qs = QS_W'(1);
        end else if (32'(r_qsz) > 32'(QS_CAP)) begin
            qs = QS_W'(QS_CAP);
        end else begin
            qs = r_qsz;
        end
    end

    assign w_twice_qs = {qs, 1'b0};
    assign pos_next   = ((r_pos + POS_W'(1) == w_twice_qs) || (r_avail == 16'hFFFF))
                        ? '0 : r_pos + POS_W'(1);

    assign accept        = start && !busy;
    assign busy          = (r_state != S_IDLE) || r_init_pend;
    assign can_pop       = (fc != '0) && (32'(fc) <= 32'(qs));
    assign cpl_slot_full = i_item.used_id[31:1];
    assign cpl_idx       = SLOT_W'(cpl_slot_full);
    assign cpl_live      = (cpl_slot_full < 31'(qs)) && meta_inflight;
    assign meta_slot     = (r_state == S_CMP) ? r_slot : cpl_idx;
    assign win_in_len    = (r_item.func == FN_SUBMIT) ? r_item.in_length : r_item.used_length;

    // Submit: pop, memory read, window check, result; completion skips the pop; others end in idle
    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_done       = 1'b0;
        n_res        = '0;
        publish      = 1'b0;
        desc_rd_en   = 1'b0;
        desc_rd_slot = cpl_idx;
        push_slot    = cpl_idx;
        stk_ctl      = '0;
        meta_ctl     = '0;
        stk_ctl.init = r_init_pend;
        meta_ctl.clear = r_init_pend;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.func)
                        FN_SUBMIT: begin
                            if (can_pop) begin
                                stk_ctl.pop = 1'b1;
                                n_state     = S_POP;
                            end else begin
                                n_done       = 1'b1;
                                n_res.status = ST_NOSLOT;
                            end
                        end
                        FN_COMPLETE: begin
                            if (cpl_live) begin
                                meta_ctl.clr = 1'b1;
                                meta_ctl.rd  = 1'b1;
                                desc_rd_en   = 1'b1;
                                stk_ctl.push = 1'b1;
                                n_slot       = cpl_idx;
                                n_state      = S_RD;
                            end else begin
                                n_done       = 1'b1;
                                n_res.status = ST_DROPPED;
                            end
                        end
                        FN_LOAD: begin
                            n_done               = 1'b1;
                            n_res.status         = ST_LOADED;
                            n_res.head_desc      = i_item.desc_index;
                            n_res.buffer_address = i_item.desc_address;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                desc_rd_en   = 1'b1;
                desc_rd_slot = stk_slot;
                n_slot       = stk_slot;
                n_state      = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state    = S_IDLE;
                n_done     = 1'b1;
                n_res.slot = 8'(r_slot);
                if (r_item.func == FN_SUBMIT) begin
                    if ((r_item.out_length > r_max) || (r_item.in_length > r_max) ||
                        ((r_item.out_length != '0) && !win_out_ok) ||
                        ((r_item.in_length != '0) && !win_in_ok)) begin
                        stk_ctl.push = 1'b1;
                        push_slot    = r_slot;
                        n_res.status = ST_REJECTED;
                    end else begin
                        publish                 = 1'b1;
                        meta_ctl.set            = 1'b1;
                        n_res.status            = ST_PUBLISHED;
                        n_res.avail_position    = 9'(r_pos);
                        n_res.avail_counter_out = r_avail + 16'd1;
                        n_res.tag               = r_item.request_tag;
                        if (r_item.out_length != '0) begin
                            n_res.buffer_address = out_addr;
                            n_res.head_desc      = 9'({r_slot, 1'b0});
                            n_res.chain_kind     = (r_item.in_length != '0) ? KIND_CHAIN
                                                                            : KIND_OUT;
                        end else begin
                            n_res.head_desc  = 9'({r_slot, 1'b1});
                            n_res.chain_kind = KIND_IN;
                        end
                    end
                end else begin
                    n_res.status      = ST_COMPLETED;
                    n_res.tag         = meta_tag;
                    n_res.done_length = r_item.used_length;
                    if (meta_has_in) begin
                        n_res.buffer_address = in_addr;
                        if ((r_item.used_length != '0) && !win_in_ok) begin
                            n_res.done_length = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Avail index and ring position, restarted with the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_init_pend) begin
            r_avail <= '0;
            r_pos   <= '0;
        end else if (publish) begin
            r_avail <= r_avail + 16'd1;
            r_pos   <= pos_next;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= '0;
            r_max       <= RST_MAX_SLOT_BYTES;
            r_qsz       <= QS_W'(RST_QUEUE_SIZE);
            r_init_pend <= 1'b0;
        end else begin
            r_init_pend <= i_cfg_we && (i_cfg_idx == CFG_QSIZE);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PHYS_BASE: r_base <= i_cfg_wdata;
                    CFG_PHYS_SIZE: r_size <= i_cfg_wdata;
                    CFG_MAX_BYTES: r_max  <= i_cfg_wdata[31:0];
                    CFG_QSIZE:     r_qsz  <= i_cfg_wdata[QS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    vqsr_free_stack #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_free_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (stk_ctl),
        .i_qs         (CNT_W'(qs)),
        .i_push_slot  (push_slot),
        .o_free_count (fc),
        .o_slot       (stk_slot)
    );

    vqsr_desc_store #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_desc_store (
        .i_clk       (i_clk),
        .i_load      (accept && (i_item.func == FN_LOAD)),
        .i_load_idx  (i_item.desc_index),
        .i_load_addr (i_item.desc_address),
        .i_rd_en     (desc_rd_en),
        .i_rd_slot   (desc_rd_slot),
        .o_out_addr  (out_addr),
        .o_in_addr   (in_addr)
    );

    vqsr_slot_meta #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_slot_meta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (meta_ctl),
        .i_slot     (meta_slot),
        .i_tag      (r_item.request_tag),
        .i_has_in   (r_item.in_length != '0),
        .o_inflight (meta_inflight),
        .o_tag      (meta_tag),
        .o_has_in   (meta_has_in)
    );

    vqsr_window_chk u_win_out (
        .i_clk  (i_clk),
        .i_adv  (r_state == S_RD),
        .i_addr (out_addr),
        .i_len  (r_item.out_length),
        .i_base (r_base),
        .i_size (r_size),
        .o_ok   (win_out_ok)
    );

    vqsr_window_chk u_win_in (
        .i_clk  (i_clk),
        .i_adv  (r_state == S_RD),
        .i_addr (in_addr),
        .i_len  (win_in_len),
        .i_base (r_base),
        .i_size (r_size),
        .o_ok   (win_in_ok)
    );

    assign o_done   = r_done;
    assign o_result = r_res;

    // Every finished submit or completion yields exactly one beat next cycle
    `VQSR_ASSERT_NEXT(a_cmp_gives_beat, r_state == S_CMP, o_done)
    // Free slots never outnumber the active queue size
    `VQSR_ASSERT_NOW(a_free_bound, !r_init_pend, 32'(fc) <= 32'(qs))
    // Ring position stays inside twice the queue size
    `VQSR_ASSERT_NOW(a_pos_bound, !r_init_pend, r_pos < w_twice_qs)

endmodule
